// ----- design/thermistor_table_interpolator_assert.svh -----
// Assertion macros shared by the thermistor table interpolator RTL.
`ifndef THERMISTOR_TABLE_INTERPOLATOR_ASSERT_SVH
`define THERMISTOR_TABLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TTI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tti_pkg.sv -----
// Shared widths, calibration ROM and controller/datapath interface types.
package tti_pkg;

  localparam int ADC_W         = 10;
  localparam int RAW_W         = 12;
  localparam int DEG_W         = 9;
  localparam int OFF_W         = RAW_W + 1;
  localparam int PROD_W        = OFF_W + DEG_W;
  localparam int FRACTION_BITS = 8;
  localparam int NUM_W         = PROD_W + FRACTION_BITS;
  localparam int ACC_W         = NUM_W + 2;
  localparam int TEMP_W        = 18;
  localparam int REP_W         = 17;
  localparam int TABLE_POINTS  = 50;
  localparam int IDX_W         = $clog2(TABLE_POINTS);
  localparam int CNT_W         = $clog2(NUM_W);
  localparam int SAMPLE_SHIFT  = 2;

  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_POINTS - 1);

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic [DEG_W-1:0] deg;
  } cal_point_t;

  typedef struct packed {
    logic load;
    logic search;
    logic prep;
    logic div_step;
    logic out_load;
  } tti_cmd_t;

  typedef struct packed {
    logic hit;
  } tti_sts_t;

  // Calibration points: raw ADC*4 non-decreasing, temperature in degrees non-increasing.
  function automatic cal_point_t cal_rom(input logic [IDX_W-1:0] idx);
    cal_point_t p;
    case (idx)
      6'd0:  p = '{raw: 12'd856,  deg: 9'd250};
      6'd1:  p = '{raw: 12'd893,  deg: 9'd245};
      6'd2:  p = '{raw: 12'd943,  deg: 9'd240};
      6'd3:  p = '{raw: 12'd1017, deg: 9'd235};
      6'd4:  p = '{raw: 12'd1104, deg: 9'd230};
      6'd5:  p = '{raw: 12'd1179, deg: 9'd225};
      6'd6:  p = '{raw: 12'd1216, deg: 9'd220};
      6'd7:  p = '{raw: 12'd1290, deg: 9'd215};
      6'd8:  p = '{raw: 12'd1414, deg: 9'd210};
      6'd9:  p = '{raw: 12'd1501, deg: 9'd205};
      6'd10: p = '{raw: 12'd1576, deg: 9'd200};
      6'd11: p = '{raw: 12'd1675, deg: 9'd195};
      6'd12: p = '{raw: 12'd1762, deg: 9'd190};
      6'd13: p = '{raw: 12'd1886, deg: 9'd185};
      6'd14: p = '{raw: 12'd1998, deg: 9'd180};
      6'd15: p = '{raw: 12'd2122, deg: 9'd175};
      6'd16: p = '{raw: 12'd2209, deg: 9'd170};
      6'd17: p = '{raw: 12'd2321, deg: 9'd165};
      6'd18: p = '{raw: 12'd2445, deg: 9'd160};
      6'd19: p = '{raw: 12'd2519, deg: 9'd155};
      6'd20: p = '{raw: 12'd2643, deg: 9'd150};
      6'd21: p = '{raw: 12'd2767, deg: 9'd145};
      6'd22: p = '{raw: 12'd2829, deg: 9'd140};
      6'd23: p = '{raw: 12'd2954, deg: 9'd135};
      6'd24: p = '{raw: 12'd3065, deg: 9'd130};
      6'd25: p = '{raw: 12'd3152, deg: 9'd125};
      6'd26: p = '{raw: 12'd3227, deg: 9'd120};
      6'd27: p = '{raw: 12'd3376, deg: 9'd115};
      6'd28: p = '{raw: 12'd3376, deg: 9'd115};
      6'd29: p = '{raw: 12'd3424, deg: 9'd110};
      6'd30: p = '{raw: 12'd3504, deg: 9'd105};
      6'd31: p = '{raw: 12'd3584, deg: 9'd100};
      6'd32: p = '{raw: 12'd3648, deg: 9'd95};
      6'd33: p = '{raw: 12'd3712, deg: 9'd90};
      6'd34: p = '{raw: 12'd3760, deg: 9'd85};
      6'd35: p = '{raw: 12'd3808, deg: 9'd80};
      6'd36: p = '{raw: 12'd3840, deg: 9'd75};
      6'd37: p = '{raw: 12'd3888, deg: 9'd70};
      6'd38: p = '{raw: 12'd3904, deg: 9'd65};
      6'd39: p = '{raw: 12'd3936, deg: 9'd60};
      6'd40: p = '{raw: 12'd3968, deg: 9'd55};
      6'd41: p = '{raw: 12'd3984, deg: 9'd50};
      6'd42: p = '{raw: 12'd4000, deg: 9'd45};
      6'd43: p = '{raw: 12'd4018, deg: 9'd40};
      6'd44: p = '{raw: 12'd4034, deg: 9'd35};
      6'd45: p = '{raw: 12'd4049, deg: 9'd30};
      6'd46: p = '{raw: 12'd4058, deg: 9'd25};
      6'd47: p = '{raw: 12'd4068, deg: 9'd20};
      6'd48: p = '{raw: 12'd4073, deg: 9'd15};
      6'd49: p = '{raw: 12'd4077, deg: 9'd10};
      default: p = '{raw: 12'd4077, deg: 9'd10};
    endcase
    return p;
  endfunction

endpackage

// ----- design/tti_datapath.sv -----
// Datapath: segment search, slope product, restoring divider, output register.
module tti_datapath import tti_pkg::*; (
  input  logic                     clk,
  input  tti_cmd_t                 cmd,
  output tti_sts_t                 sts,
  input  logic [ADC_W-1:0]         adc_sample,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [REP_W-1:0]         reported_temperature
);

  logic [RAW_W-1:0]         scaled;
  logic [IDX_W-1:0]         idx;
  logic [RAW_W-1:0]         den;
  logic [DEG_W-1:0]         base_deg;
  logic                     neg;
  logic [NUM_W-1:0]         quo;
  logic [RAW_W-1:0]         rem;

  cal_point_t               closing;
  cal_point_t               opening;
  cal_point_t               floor_pt;
  logic [RAW_W-1:0]         den_c;
  logic                     den_zero;
  logic signed [OFF_W-1:0]  offset;
  logic signed [DEG_W-1:0]  slope;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_mag;
  logic [RAW_W:0]           rem_sh;
  logic [RAW_W:0]           trial;
  logic signed [ACC_W-1:0]  base_fix;
  logic signed [ACC_W-1:0]  quo_ext;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  floor_fix;

  always_comb begin
    closing  = cal_rom(idx);
    opening  = cal_rom(idx - IDX_W'(1));
    floor_pt = cal_rom(LAST_IDX);
    sts.hit  = (scaled <= closing.raw) || (idx == LAST_IDX);

    den_c    = closing.raw - opening.raw;
    den_zero = (den_c == '0);
    offset   = $signed({1'b0, scaled}) - $signed({1'b0, opening.raw});
    slope    = $signed(closing.deg) - $signed(opening.deg);
    prod     = PROD_W'(offset) * PROD_W'(slope);
    prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

    rem_sh   = {rem, quo[NUM_W-1]};
    trial    = rem_sh - {1'b0, den};

    base_fix  = $signed(ACC_W'({base_deg, {FRACTION_BITS{1'b0}}}));
    quo_ext   = $signed(ACC_W'(quo));
    sum       = neg ? (base_fix - quo_ext) : (base_fix + quo_ext);
    floor_fix = $signed(ACC_W'({floor_pt.deg, {FRACTION_BITS{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scaled <= RAW_W'(adc_sample) << SAMPLE_SHIFT;
      idx    <= FIRST_IDX;
    end else if (cmd.search && !sts.hit) begin
      idx <= idx + IDX_W'(1);
    end

    if (cmd.prep) begin
      // flat segment: colder point, zero quotient (divide by one)
      den      <= den_zero ? RAW_W'(1) : den_c;
      base_deg <= den_zero ? closing.deg : opening.deg;
      neg      <= prod[PROD_W-1];
      quo      <= den_zero ? '0 : {prod_mag, {FRACTION_BITS{1'b0}}};
      rem      <= '0;
    end else if (cmd.div_step) begin
      if (!trial[RAW_W]) begin
        rem <= trial[RAW_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[RAW_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      temperature          <= sum[TEMP_W-1:0];
      reported_temperature <= (sum < floor_fix) ? floor_fix[REP_W-1:0] : sum[REP_W-1:0];
    end
  end

endmodule

// ----- design/tti_ctrl.sv -----
// Controller: request sequencing, divide step count and output valid.
module tti_ctrl import tti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output tti_cmd_t cmd,
  input  tti_sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_DIVIDE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    in_stall     = (state != S_IDLE);
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.search   = (state == S_SEARCH);
    cmd.prep     = (state == S_PREP);
    cmd.div_step = (state == S_DIVIDE);
    cmd.out_load = (state == S_FINISH) && (!out_valid || !out_stall);

    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_SEARCH;
      S_SEARCH: if (sts.hit) state_next = S_PREP;
      S_PREP:   state_next = S_DIVIDE;
      S_DIVIDE: if (cnt == CNT_W'(NUM_W - 1)) state_next = S_FINISH;
      S_FINISH: if (cmd.out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.prep) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/thermistor_table_interpolator.sv -----
// Thermistor ADC sample to temperature by piecewise-linear table lookup.
// Request to result valid: load, segment search (one ROM point per cycle), prep,
// restoring divide (one quotient bit per divide step, 30 bits), then finish.
// One request at a time (in_stall while busy); finish waits on out_stall; result register frees input.
// Reset (rst, synchronous): controller to idle, result valid cleared.
`include "thermistor_table_interpolator_assert.svh"
module thermistor_table_interpolator import tti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ADC_W-1:0]         adc_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [REP_W-1:0]         reported_temperature
);

  // Flow per request:
  //   load   - sample scaled by four, search starts at the second point
  //   search - walk the ROM until the scaled sample is not above a point's
  //            raw value; the last point always ends the walk, and a sample
  //            below the first point lands on the first segment
  //   prep   - offset * slope product, sign split off for the divider
  //   divide - restoring divide of |product| << 8 by the segment raw span,
  //            giving a quotient truncated toward zero
  //   finish - hot-point base plus signed quotient into the result register,
  //            reported value clamped at the coldest point's temperature
  tti_cmd_t cmd;
  tti_sts_t sts;

  tti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tti_datapath u_datapath (
    .clk                  (clk),
    .cmd                  (cmd),
    .sts                  (sts),
    .adc_sample           (adc_sample),
    .temperature          (temperature),
    .reported_temperature (reported_temperature)
  );

  // Only one datapath operation per cycle.
  `TTI_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.search, cmd.prep, cmd.div_step, cmd.out_load}), "more than one datapath command")
  // A pending result is never overwritten.
  `TTI_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || !out_stall, "result register overwritten while stalled")
  // An accepted request keeps the block busy.
  `TTI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall && !cmd.out_load, "block not busy after request")

endmodule
